@@ sv/ssfa_pkg.sv @@
// ----------------------------------------------------------------------------
// ssfa_pkg
// Shared widths, codes and control structs of the sprite sheet animator.
// ----------------------------------------------------------------------------
package ssfa_pkg;

   localparam int unsigned DIM_W       = 7;
   localparam int unsigned FRAME_W     = 12;
   localparam int unsigned COUNT_W     = 13;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned DELTA_W     = 20;
   localparam int unsigned UV_W        = 17;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned REQ_DATA_W  = 24;
   localparam int unsigned REQ_USER_W  = 2;
   localparam int unsigned RSP_DATA_W  = 88;
   localparam int unsigned FRAME_CAP   = 4096;

   localparam logic [DIM_W-1:0]  COLS_RESET   = 7'd1;
   localparam logic [DIM_W-1:0]  ROWS_RESET   = 7'd1;
   localparam logic [TIME_W-1:0] PERIOD_RESET = 32'd2184;
   localparam logic              LOOP_RESET   = 1'b1;

   typedef enum logic [1:0] {
      REQ_TICK    = 2'd0,
      REQ_PLAY    = 2'd1,
      REQ_STOP    = 2'd2,
      REQ_RESTART = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLS   = 2'd0,
      CSR_ROWS   = 2'd1,
      CSR_PERIOD = 2'd2,
      CSR_LOOP   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [TIME_W-1:0]  period;
      logic               loop_en;
      logic [COUNT_W-1:0] frames;
   } anim_cfg_type;

   typedef struct packed {
      logic               done;
      logic [FRAME_W-1:0] frame;
      logic               playing;
      logic               advanced;
   } anim_status_type;

endpackage

@@ sv/ssfa_sdiv.sv @@
// ----------------------------------------------------------------------------
// ssfa_sdiv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module ssfa_sdiv #(
   parameter int unsigned NUM_W = 12,
   parameter int unsigned DEN_W = 7,
   parameter int unsigned Q_W   = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [Q_W-1:0]   quot,
   output logic [DEN_W-1:0] rem
);

   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [Q_W-1:0]   quot_ff, quot_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         quot_in = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift the next numerator bit into the partial remainder
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quot_in = {quot_ff[Q_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

@@ sv/ssfa_anim.sv @@
// ----------------------------------------------------------------------------
// ssfa_anim
// Playback state: elapsed time accumulator, current frame and play flag.
// ----------------------------------------------------------------------------
module ssfa_anim (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [1:0]                       req_kind,
   input  logic [ssfa_pkg::DELTA_W-1:0]     delta,
   input  ssfa_pkg::anim_cfg_type           cfg,
   output ssfa_pkg::anim_status_type        status
);

   import ssfa_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'b01,
      PH_CHECK = 2'b10
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic               play_ff, play_in;
   logic               adv_ff, adv_in;
   logic               done_ff, done_in;
   logic [TIME_W:0]    sum;
   logic [TIME_W-1:0]  sum_sat;
   logic [TIME_W:0]    diff;
   logic               reached;
   logic [COUNT_W-1:0] next_cnt;
   logic [COUNT_W-1:0] frames_m1;
   logic               wrap;
   logic [FRAME_W-1:0] next_frame;

   assign sum       = {1'b0, elapsed_ff} + {{(TIME_W + 1 - DELTA_W){1'b0}}, delta};
   assign sum_sat   = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
   assign diff      = {1'b0, elapsed_ff} - {1'b0, cfg.period};
   assign reached   = !diff[TIME_W];
   assign next_cnt  = {1'b0, frame_ff} + COUNT_W'(1);
   assign frames_m1 = cfg.frames - COUNT_W'(1);
   assign wrap      = next_cnt >= cfg.frames;

   always_comb begin
      if (!wrap) begin
         next_frame = next_cnt[FRAME_W-1:0];
      end else if (cfg.loop_en) begin
         next_frame = '0;
      end else begin
         next_frame = frames_m1[FRAME_W-1:0];
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      frame_in   = frame_ff;
      play_in    = play_ff;
      adv_in     = adv_ff;
      done_in    = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               adv_in = 1'b0;
               case (req_kind_type'(req_kind))
                  REQ_TICK: begin
                     if (play_ff) begin
                        elapsed_in = sum_sat;
                        phase_in   = PH_CHECK;
                     end else begin
                        done_in = 1'b1;
                     end
                  end
                  REQ_PLAY: begin
                     play_in = 1'b1;
                     done_in = 1'b1;
                  end
                  REQ_STOP: begin
                     play_in = 1'b0;
                     done_in = 1'b1;
                  end
                  REQ_RESTART: begin
                     frame_in   = '0;
                     elapsed_in = '0;
                     adv_in     = frame_ff != '0;
                     done_in    = 1'b1;
                  end
                  default: begin
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         PH_CHECK: begin
            // at most one frame step per tick
            if (reached) begin
               elapsed_in = diff[TIME_W-1:0];
               frame_in   = next_frame;
               adv_in     = next_frame != frame_ff;
               if (wrap && !cfg.loop_en) begin
                  play_in = 1'b0;
               end
            end
            phase_in = PH_IDLE;
            done_in  = 1'b1;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         elapsed_ff <= '0;
         frame_ff   <= '0;
         play_ff    <= 1'b0;
         adv_ff     <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         frame_ff   <= frame_in;
         play_ff    <= play_in;
         adv_ff     <= adv_in;
         done_ff    <= done_in;
      end
   end

   assign status.done     = done_ff;
   assign status.frame    = frame_ff;
   assign status.playing  = play_ff;
   assign status.advanced = adv_ff;

endmodule

@@ sv/sprite_sheet_frame_animator_core.sv @@
// ----------------------------------------------------------------------------
// sprite_sheet_frame_animator_core
// Flipbook animator over a sprite sheet with per-item frame and UV rectangle.
// Flow: each accepted beat runs the playback update (with a check step for a
//   tick while playing), the 12-step frame divider, then the
//   (7 + UV_FRAC_BITS)-step bit-serial UV edge dividers, before the result is
//   loaded; no new beat is accepted until then, and a held result stalls it.
// Reset: synchronous; restores register defaults, clears frame, elapsed time
//   and playing; no clearing pass.
// ----------------------------------------------------------------------------
module sprite_sheet_frame_animator_core #(
   parameter int MAX_SHEET_DIM = 64,
   parameter int UV_FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // delta_time[19:0], zero fill [23:20]
   input  logic [ssfa_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type[1:0]
   input  logic [ssfa_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // frame_index[11:0], uv_min_u[28:12], uv_min_v[45:29], uv_max_u[62:46],
   // uv_max_v[79:63], is_playing[80], frame_advanced[81], zero fill [87:82]
   output logic [ssfa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ssfa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ssfa_pkg::CSR_DATA_W-1:0]     csr_data
);

   import ssfa_pkg::*;

   localparam int unsigned EDGE_NUM_W = DIM_W + UV_FRAC_BITS;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_UPD  = 5'b00010,
      ST_FDIV = 5'b00100,
      ST_EDIV = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end
      if (int'(v) > MAX_SHEET_DIM) begin
         return DIM_W'(MAX_SHEET_DIM);
      end
      return v;
   endfunction

   state_type              state_ff, state_in;
   logic [DIM_W-1:0]       cols_ff, rows_ff;
   logic [TIME_W-1:0]      period_ff;
   logic                   loop_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [DIM_W-1:0]       cols_eff, rows_eff;
   logic [2*DIM_W-1:0]     frames_prod;
   logic [COUNT_W-1:0]     frames, frames_m1;
   anim_cfg_type           anim_cfg;
   anim_status_type        anim_st;
   logic                   req_acc;
   logic [FRAME_W-1:0]     shown;

   logic                   fdiv_start, fdiv_done;
   logic [FRAME_W-1:0]     fdiv_quot;
   logic [DIM_W-1:0]       fdiv_rem;
   logic [DIM_W-1:0]       row_cl, col_p1, row_p1;
   logic                   edge_start;
   logic                   umin_done, vmin_done, umax_done, vmax_done;
   logic [UV_W-1:0]        umin_q, vmin_q, umax_q, vmax_q;
   logic [DIM_W-1:0]       umin_r, vmin_r, umax_r, vmax_r;
   logic                   rsp_load;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff   <= COLS_RESET;
         rows_ff   <= ROWS_RESET;
         period_ff <= PERIOD_RESET;
         loop_ff   <= LOOP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_COLS:   cols_ff   <= csr_data[DIM_W-1:0];
            CSR_ROWS:   rows_ff   <= csr_data[DIM_W-1:0];
            CSR_PERIOD: period_ff <= csr_data[TIME_W-1:0];
            CSR_LOOP:   loop_ff   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign cols_eff    = eff_dim(cols_ff);
   assign rows_eff    = eff_dim(rows_ff);
   assign frames_prod = (2*DIM_W)'(cols_eff) * (2*DIM_W)'(rows_eff);
   assign frames      = (frames_prod > (2*DIM_W)'(FRAME_CAP)) ? COUNT_W'(FRAME_CAP)
                                                               : frames_prod[COUNT_W-1:0];
   assign frames_m1   = frames - COUNT_W'(1);

   assign anim_cfg.period  = period_ff;
   assign anim_cfg.loop_en = loop_ff;
   assign anim_cfg.frames  = frames;

   assign req_tready = state_ff == ST_IDLE;
   assign req_acc    = req_tvalid && req_tready;

   ssfa_anim u_anim (
      .clock    (clock),
      .reset    (reset),
      .start    (req_acc),
      .req_kind (req_tuser),
      .delta    (req_tdata[DELTA_W-1:0]),
      .cfg      (anim_cfg),
      .status   (anim_st)
   );

   // a stale frame past the sheet end shows the last cell
   assign shown = ({1'b0, anim_st.frame} < frames) ? anim_st.frame
                                                    : frames_m1[FRAME_W-1:0];

   assign fdiv_start = (state_ff == ST_UPD) && anim_st.done;

   ssfa_sdiv #(
      .NUM_W (FRAME_W),
      .DEN_W (DIM_W),
      .Q_W   (FRAME_W)
   ) u_fdiv (
      .clock (clock),
      .reset (reset),
      .start (fdiv_start),
      .numer (shown),
      .denom (cols_eff),
      .done  (fdiv_done),
      .quot  (fdiv_quot),
      .rem   (fdiv_rem)
   );

   assign row_cl     = (fdiv_quot >= FRAME_W'(rows_eff)) ? rows_eff - DIM_W'(1)
                                                         : fdiv_quot[DIM_W-1:0];
   assign col_p1     = fdiv_rem + DIM_W'(1);
   assign row_p1     = row_cl + DIM_W'(1);
   assign edge_start = (state_ff == ST_FDIV) && fdiv_done;

   ssfa_sdiv #(
      .NUM_W (EDGE_NUM_W),
      .DEN_W (DIM_W),
      .Q_W   (UV_W)
   ) u_umin (
      .clock (clock),
      .reset (reset),
      .start (edge_start),
      .numer ({fdiv_rem, {UV_FRAC_BITS{1'b0}}}),
      .denom (cols_eff),
      .done  (umin_done),
      .quot  (umin_q),
      .rem   (umin_r)
   );

   ssfa_sdiv #(
      .NUM_W (EDGE_NUM_W),
      .DEN_W (DIM_W),
      .Q_W   (UV_W)
   ) u_vmin (
      .clock (clock),
      .reset (reset),
      .start (edge_start),
      .numer ({row_cl, {UV_FRAC_BITS{1'b0}}}),
      .denom (rows_eff),
      .done  (vmin_done),
      .quot  (vmin_q),
      .rem   (vmin_r)
   );

   ssfa_sdiv #(
      .NUM_W (EDGE_NUM_W),
      .DEN_W (DIM_W),
      .Q_W   (UV_W)
   ) u_umax (
      .clock (clock),
      .reset (reset),
      .start (edge_start),
      .numer ({col_p1, {UV_FRAC_BITS{1'b0}}}),
      .denom (cols_eff),
      .done  (umax_done),
      .quot  (umax_q),
      .rem   (umax_r)
   );

   ssfa_sdiv #(
      .NUM_W (EDGE_NUM_W),
      .DEN_W (DIM_W),
      .Q_W   (UV_W)
   ) u_vmax (
      .clock (clock),
      .reset (reset),
      .start (edge_start),
      .numer ({row_p1, {UV_FRAC_BITS{1'b0}}}),
      .denom (rows_eff),
      .done  (vmax_done),
      .quot  (vmax_q),
      .rem   (vmax_r)
   );

   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_acc) state_in = ST_UPD;
         ST_UPD:  if (anim_st.done) state_in = ST_FDIV;
         ST_FDIV: if (fdiv_done) state_in = ST_EDIV;
         ST_EDIV: begin
            if (umin_done && vmin_done && umax_done && vmax_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT:  if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // result register, holds a beat while the next item runs
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'b0, anim_st.advanced, anim_st.playing,
                         vmax_q, umax_q, vmin_q, umin_q, anim_st.frame};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   logic unused_rem;
   assign unused_rem = ^{umin_r, vmin_r, umax_r, vmax_r};

   a_anim_done_in_upd: assert property (@(posedge clock) disable iff (reset)
      anim_st.done |-> state_ff == ST_UPD)
      else $error("playback update finished outside its state");

   a_fdiv_done_in_fdiv: assert property (@(posedge clock) disable iff (reset)
      fdiv_done |-> state_ff == ST_FDIV)
      else $error("frame divider finished outside its state");

   a_edges_lockstep: assert property (@(posedge clock) disable iff (reset)
      umin_done |-> (vmin_done && umax_done && vmax_done))
      else $error("uv edge dividers out of step");

   a_accept_starts_update: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == ST_UPD)
      else $error("accepted beat did not start an update");
`endif

endmodule
